[src/refcounted_handle_pool_manager_core_assert.svh]
// assertion macros for the handle pool manager
// used by the top level only, needs clk and rst_n in scope
`ifndef REFCOUNTED_HANDLE_POOL_MANAGER_CORE_ASSERT_SVH
`define REFCOUNTED_HANDLE_POOL_MANAGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RHP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle pool check failed");
`define RHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle pool check failed");
`else
`define RHP_ASSERT_SAME(label, ante, cons)
`define RHP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/rhp_pkg.sv]
// shared types and codes for the handle pool manager
// no dependencies
package rhp_pkg;

    localparam int POOLS_DEF      = 16;
    localparam int HANDLES_DEF    = 1024;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [2:0] KIND_NEW    = 3'd0;
    localparam logic [2:0] KIND_RETIRE = 3'd1;
    localparam logic [2:0] KIND_ALLOC  = 3'd2;
    localparam logic [2:0] KIND_IMPORT = 3'd3;
    localparam logic [2:0] KIND_REF    = 3'd4;
    localparam logic [2:0] KIND_UNREF  = 3'd5;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_POOL_INVALID = 3'd1;
    localparam logic [2:0] ST_POOL_EMPTY   = 3'd2;
    localparam logic [2:0] ST_NOT_LIVE     = 3'd3;
    localparam logic [2:0] ST_COUNT_FULL   = 3'd4;
    localparam logic [2:0] ST_ALREADY_LIVE = 3'd5;
    localparam logic [2:0] ST_NO_POOL      = 3'd6;

    typedef struct packed {
        logic       load;
        logic       setup_begin;
        logic       boot_sel;
        logic       boot_pool;
        logic       setup_write;
        logic       setup_finish;
        logic       retire;
        logic       rd_top;
        logic       rd_stack;
        logic       rd_ref;
        logic       latch_top;
        logic       idx_inc;
        logic       alloc_commit;
        logic       swap_commit;
        logic       cnt_load;
        logic       ref_update;
        logic       set_status;
        logic [2:0] status_code;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       pool_ok;
        logic       h_ok;
        logic       n_zero;
        logic       any_free;
        logic       setup_last;
        logic       scan_last;
        logic       match;
        logic       ref_zero;
        logic       ref_full;
        logic       out_free;
    } sts_t;

endpackage

[src/rhp_dp.sv]
// datapath: pool flags, free counts, stack and count memories, result register
// depends on rhp_pkg
module rhp_dp #(
    parameter int POOLS      = rhp_pkg::POOLS_DEF,
    parameter int HANDLES    = rhp_pkg::HANDLES_DEF,
    parameter int COUNT_BITS = rhp_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [2:0]    kind,
    input  logic [3:0]    pool_index,
    input  logic [9:0]    handle_in,
    input  rhp_pkg::cmd_t cmd,
    output rhp_pkg::sts_t sts,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    status,
    output logic [3:0]    pool_out,
    output logic [9:0]    handle_out,
    output logic [15:0]   count_out
);
    import rhp_pkg::*;

    localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int IW = (HANDLES > 1) ? $clog2(HANDLES) : 1;
    localparam int NW = $clog2(HANDLES + 1);
    localparam int AW = PW + IW;
    localparam int CB = COUNT_BITS;

    logic [IW-1:0] stack_mem [0:(1 << AW) - 1];
    logic [CB-1:0] ref_mem [0:(1 << AW) - 1];

    logic          valid_reg [POOLS];
    logic [NW-1:0] fcnt_reg [POOLS];

    logic [2:0]    kind_reg;
    logic [3:0]    pool_reg;
    logic [9:0]    h_reg;
    logic [PW-1:0] sp_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] top_reg;
    logic [IW-1:0] stack_q;
    logic [CB-1:0] ref_q;
    logic [CB-1:0] cnt_reg;
    logic [3:0]    pout_reg;
    logic [9:0]    hout_reg;
    logic [2:0]    st_reg;
    logic          out_valid_reg;
    logic [2:0]    out_st_reg;
    logic [3:0]    out_pool_reg;
    logic [9:0]    out_h_reg;
    logic [15:0]   out_cnt_reg;

    logic [PW-1:0] pi;
    logic [IW-1:0] hi;
    logic [NW-1:0] n;
    logic [PW-1:0] free_pool;
    logic          any_free;
    logic [CB-1:0] newc;
    logic          push;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [IW-1:0] stk_wdata;
    logic          ref_we;
    logic [AW-1:0] ref_waddr;
    logic [CB-1:0] ref_wdata;
    logic [AW-1:0] stk_raddr;

    assign pi = PW'(pool_reg);
    assign hi = IW'(h_reg);
    assign n  = fcnt_reg[pi];

    always_comb
    begin
        free_pool = '0;
        any_free  = 1'b0;
        for (int i = POOLS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_pool = PW'(i);
                any_free  = 1'b1;
            end
        end
    end

    assign newc = (kind_reg == KIND_REF) ? ref_q + CB'(1) : ref_q - CB'(1);
    assign push = cmd.ref_update && (kind_reg == KIND_UNREF) && (newc == '0)
                  && (n < NW'(HANDLES));

    assign sts.kind       = kind_reg;
    assign sts.pool_ok    = (32'(pool_reg) < POOLS) && valid_reg[pi];
    assign sts.h_ok       = 32'(h_reg) < HANDLES;
    assign sts.n_zero     = (n == '0);
    assign sts.any_free   = any_free;
    assign sts.setup_last = (idx_reg == IW'(HANDLES - 1));
    assign sts.scan_last  = ((NW'(idx_reg) + NW'(1)) == n);
    assign sts.match      = (stack_q == hi);
    assign sts.ref_zero   = (ref_q == '0);
    assign sts.ref_full   = (ref_q == '1);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // one write port per memory, picked by the active command
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = {sp_reg, idx_reg};
        stk_wdata = IW'(HANDLES - 1) - idx_reg;
        ref_we    = 1'b0;
        ref_waddr = {sp_reg, idx_reg};
        ref_wdata = '0;
        if (cmd.setup_write)
        begin
            stk_we = 1'b1;
            ref_we = 1'b1;
        end
        if (cmd.swap_commit)
        begin
            stk_we    = 1'b1;
            stk_waddr = {pi, idx_reg};
            stk_wdata = top_reg;
            ref_we    = 1'b1;
            ref_waddr = {pi, hi};
            ref_wdata = CB'(1);
        end
        if (cmd.alloc_commit)
        begin
            ref_we    = 1'b1;
            ref_waddr = {pi, stack_q};
            ref_wdata = CB'(1);
        end
        if (cmd.ref_update)
        begin
            ref_we    = 1'b1;
            ref_waddr = {pi, hi};
            ref_wdata = newc;
        end
        if (push)
        begin
            stk_we    = 1'b1;
            stk_waddr = {pi, IW'(n)};
            stk_wdata = hi;
        end
    end

    assign stk_raddr = cmd.rd_top ? {pi, IW'(n - NW'(1))} : {pi, idx_reg};

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (cmd.rd_top || cmd.rd_stack)
        begin
            stack_q <= stack_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        if (cmd.rd_ref)
        begin
            ref_q <= ref_mem[{pi, hi}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOLS; i++)
            begin
                valid_reg[i] <= 1'b0;
                fcnt_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.setup_finish)
            begin
                valid_reg[sp_reg] <= 1'b1;
                fcnt_reg[sp_reg]  <= NW'(HANDLES);
            end
            if (cmd.retire)
            begin
                valid_reg[pi] <= 1'b0;
            end
            if (cmd.alloc_commit || cmd.swap_commit)
            begin
                fcnt_reg[pi] <= n - NW'(1);
            end
            if (push)
            begin
                fcnt_reg[pi] <= n + NW'(1);
            end
        end
    end

    // request fields and working values
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            pool_reg <= pool_index;
            h_reg    <= handle_in;
            pout_reg <= (kind == KIND_NEW) ? 4'd0 : pool_index;
            hout_reg <= (kind == KIND_IMPORT || kind == KIND_REF || kind == KIND_UNREF)
                        ? handle_in : 10'd0;
            cnt_reg  <= '0;
        end
        if (cmd.setup_begin)
        begin
            sp_reg  <= cmd.boot_sel ? PW'(cmd.boot_pool) : free_pool;
            idx_reg <= '0;
            if (!cmd.boot_sel)
            begin
                pout_reg <= 4'(free_pool);
            end
        end
        if (cmd.rd_top)
        begin
            idx_reg <= '0;
        end
        if (cmd.setup_write || cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.latch_top)
        begin
            top_reg <= stack_q;
        end
        if (cmd.alloc_commit)
        begin
            hout_reg <= 10'(stack_q);
            cnt_reg  <= CB'(1);
        end
        if (cmd.swap_commit)
        begin
            cnt_reg <= CB'(1);
        end
        if (cmd.cnt_load)
        begin
            cnt_reg <= ref_q;
        end
        if (cmd.ref_update)
        begin
            cnt_reg <= newc;
        end
        if (cmd.set_status)
        begin
            st_reg <= cmd.status_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_st_reg   <= st_reg;
            out_pool_reg <= pout_reg;
            out_h_reg    <= hout_reg;
            out_cnt_reg  <= 16'(cnt_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_st_reg;
    assign pool_out   = out_pool_reg;
    assign handle_out = out_h_reg;
    assign count_out  = out_cnt_reg;

endmodule

[src/rhp_ctrl.sv]
// controller state machine for the handle pool manager
// depends on rhp_pkg, drives rhp_dp through cmd_t
module rhp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rhp_pkg::sts_t sts,
    output rhp_pkg::cmd_t cmd
);
    import rhp_pkg::*;

    localparam logic [3:0] S_BOOT     = 4'd0;
    localparam logic [3:0] S_FILL     = 4'd1;
    localparam logic [3:0] S_FILLEND  = 4'd2;
    localparam logic [3:0] S_IDLE     = 4'd3;
    localparam logic [3:0] S_DECODE   = 4'd4;
    localparam logic [3:0] S_ALLOC    = 4'd5;
    localparam logic [3:0] S_IMP_TOP  = 4'd6;
    localparam logic [3:0] S_IMP_CMP  = 4'd7;
    localparam logic [3:0] S_IMP_RD   = 4'd8;
    localparam logic [3:0] S_IMP_LIVE = 4'd9;
    localparam logic [3:0] S_REF      = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       boot_reg, boot_next;
    logic       bpool_reg, bpool_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            boot_reg  <= 1'b1;
            bpool_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
            bpool_reg <= bpool_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        boot_next  = boot_reg;
        bpool_next = bpool_reg;
        case (state_reg)
            S_BOOT:
            begin
                cmd.setup_begin = 1'b1;
                cmd.boot_sel    = 1'b1;
                cmd.boot_pool   = bpool_reg;
                state_next      = S_FILL;
            end
            S_FILL:
            begin
                cmd.setup_write = 1'b1;
                if (sts.setup_last)
                begin
                    state_next = S_FILLEND;
                end
            end
            S_FILLEND:
            begin
                cmd.setup_finish = 1'b1;
                if (boot_reg)
                begin
                    if (bpool_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        bpool_next = 1'b1;
                        state_next = S_BOOT;
                    end
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_DONE;
                if (sts.kind == KIND_NEW)
                begin
                    if (sts.any_free)
                    begin
                        cmd.set_status  = 1'b0;
                        cmd.setup_begin = 1'b1;
                        state_next      = S_FILL;
                    end
                    else
                    begin
                        cmd.status_code = ST_NO_POOL;
                    end
                end
                else if (sts.kind != KIND_RETIRE && sts.kind != KIND_ALLOC
                         && sts.kind != KIND_IMPORT && sts.kind != KIND_REF
                         && sts.kind != KIND_UNREF)
                begin
                    // undefined kinds give no result
                    cmd.set_status = 1'b0;
                    state_next     = S_IDLE;
                end
                else if (!sts.pool_ok)
                begin
                    cmd.status_code = ST_POOL_INVALID;
                end
                else if (sts.kind == KIND_RETIRE)
                begin
                    cmd.retire      = 1'b1;
                    cmd.status_code = ST_OK;
                end
                else if (sts.kind == KIND_ALLOC)
                begin
                    if (sts.n_zero)
                    begin
                        cmd.status_code = ST_POOL_EMPTY;
                    end
                    else
                    begin
                        cmd.set_status = 1'b0;
                        cmd.rd_top     = 1'b1;
                        state_next     = S_ALLOC;
                    end
                end
                else if (!sts.h_ok)
                begin
                    cmd.status_code = ST_NOT_LIVE;
                end
                else if (sts.kind == KIND_IMPORT)
                begin
                    cmd.set_status = 1'b0;
                    if (sts.n_zero)
                    begin
                        cmd.rd_ref = 1'b1;
                        state_next = S_IMP_LIVE;
                    end
                    else
                    begin
                        cmd.rd_top = 1'b1;
                        state_next = S_IMP_TOP;
                    end
                end
                else
                begin
                    cmd.set_status = 1'b0;
                    cmd.rd_ref     = 1'b1;
                    state_next     = S_REF;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_commit = 1'b1;
                cmd.set_status   = 1'b1;
                cmd.status_code  = ST_OK;
                state_next       = S_DONE;
            end
            S_IMP_TOP:
            begin
                cmd.latch_top = 1'b1;
                cmd.rd_stack  = 1'b1;
                state_next    = S_IMP_CMP;
            end
            S_IMP_CMP:
            begin
                if (sts.match)
                begin
                    cmd.swap_commit = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OK;
                    state_next      = S_DONE;
                end
                else if (sts.scan_last)
                begin
                    cmd.rd_ref = 1'b1;
                    state_next = S_IMP_LIVE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_IMP_RD;
                end
            end
            S_IMP_RD:
            begin
                cmd.rd_stack = 1'b1;
                state_next   = S_IMP_CMP;
            end
            S_IMP_LIVE:
            begin
                cmd.cnt_load    = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_ALREADY_LIVE;
                state_next      = S_DONE;
            end
            S_REF:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_DONE;
                if (sts.ref_zero)
                begin
                    cmd.status_code = ST_NOT_LIVE;
                end
                else if (sts.kind == KIND_REF && sts.ref_full)
                begin
                    cmd.cnt_load    = 1'b1;
                    cmd.status_code = ST_COUNT_FULL;
                end
                else
                begin
                    cmd.ref_update  = 1'b1;
                    cmd.status_code = ST_OK;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/refcounted_handle_pool_manager_core.sv]
// handle pool manager: import walks up to the n free ids of its pool (one stack read and
// one compare per entry), a new pool writes one stack entry per cycle; one request in
// flight, the next is taken once the controller is back in idle after the result
// register loads; after reset pools 0 and 1 are swept with stall high; depends on
// rhp_pkg, rhp_ctrl, rhp_dp, assert header
`include "refcounted_handle_pool_manager_core_assert.svh"

module refcounted_handle_pool_manager_core #(
    parameter int POOLS      = rhp_pkg::POOLS_DEF,
    parameter int HANDLES    = rhp_pkg::HANDLES_DEF,
    parameter int COUNT_BITS = rhp_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [3:0]  pool_index,
    input  logic [9:0]  handle_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  pool_out,
    output logic [9:0]  handle_out,
    output logic [15:0] count_out
);
    import rhp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: boot sweep, decode, stack scan, count update, result hand-off
    rhp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // pool flags, free counts, stack and count memories, result register
    rhp_dp #(
        .POOLS      (POOLS),
        .HANDLES    (HANDLES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .pool_index (pool_index),
        .handle_in  (handle_in),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .pool_out   (pool_out),
        .handle_out (handle_out),
        .count_out  (count_out)
    );

    // an accepted request keeps the input side closed for the next cycle
    `RHP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // a result is only loaded when the output register can take it
    `RHP_ASSERT_SAME(a_emit_when_free, cmd.emit, sts.out_free)
    // a new result always comes from an emit command
    `RHP_ASSERT_SAME(a_valid_from_emit, $rose(out_valid), $past(cmd.emit))

endmodule

[tb/refcounted_handle_pool_manager_core_chk.sv]
`timescale 1ns / 100ps
// checker for the handle pool manager: watches both channels, predicts each result
// from its own copy of the pools and compares field by field; depends on rhp_pkg
module refcounted_handle_pool_manager_core_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [3:0]  pool_index,
    input  logic [9:0]  handle_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [3:0]  pool_out,
    input  logic [9:0]  handle_out,
    input  logic [15:0] count_out,
    output int          errors,
    output int          pending
);
    import rhp_pkg::*;

    localparam int NPOOL   = POOLS_DEF;
    localparam int NHANDLE = HANDLES_DEF;
    localparam int CMAX    = (1 << COUNT_BITS_DEF) - 1;

    typedef struct packed {
        logic [2:0]  st;
        logic [3:0]  pl;
        logic [9:0]  hd;
        logic [15:0] ct;
    } answer_t;

    bit         live_pool [NPOOL];
    int         free_n    [NPOOL];
    logic [9:0] free_ids  [NPOOL][NHANDLE];
    int         refs      [NPOOL][NHANDLE];
    answer_t    answers_due[$];

    assign pending = answers_due.size();

    function automatic void fill_pool(int p);
        for (int i = 0; i < NHANDLE; i++) begin
            free_ids[p][i] = 10'(NHANDLE - 1 - i);
            refs[p][i] = 0;
        end
        free_n[p] = NHANDLE;
        live_pool[p] = 1'b1;
    endfunction

    function automatic void clear_pools();
        for (int p = 0; p < NPOOL; p++) begin
            live_pool[p] = 1'b0;
            free_n[p] = 0;
            for (int i = 0; i < NHANDLE; i++) begin
                free_ids[p][i] = '0;
                refs[p][i] = 0;
            end
        end
        fill_pool(0);
        fill_pool(1);
    endfunction

    // returns 0 for kinds that give no result
    function automatic bit pool_answer(input logic [2:0] k, input logic [3:0] p,
                                       input logic [9:0] h, output answer_t a);
        int n;
        int c;
        a = '{st: ST_OK, pl: p, hd: '0, ct: '0};
        if (k > KIND_UNREF) return 1'b0;
        if (k == KIND_NEW) begin
            for (int i = 0; i < NPOOL; i++) begin
                if (!live_pool[i]) begin
                    fill_pool(i);
                    a.pl = 4'(i);
                    return 1'b1;
                end
            end
            a.st = ST_NO_POOL;
            a.pl = '0;
            return 1'b1;
        end
        if (!live_pool[p]) begin
            a.st = ST_POOL_INVALID;
            if (k != KIND_RETIRE && k != KIND_ALLOC) a.hd = h;
            return 1'b1;
        end
        if (k == KIND_RETIRE) begin
            live_pool[p] = 1'b0;
            return 1'b1;
        end
        if (k == KIND_ALLOC) begin
            n = free_n[p];
            if (n == 0) begin
                a.st = ST_POOL_EMPTY;
                return 1'b1;
            end
            a.hd = free_ids[p][n-1];
            free_n[p] = n - 1;
            refs[p][a.hd] = 1;
            a.ct = 16'd1;
            return 1'b1;
        end
        a.hd = h;
        if (k == KIND_IMPORT) begin
            n = free_n[p];
            for (int i = 0; i < n; i++) begin
                if (free_ids[p][i] == h) begin
                    free_ids[p][i] = free_ids[p][n-1];
                    free_n[p] = n - 1;
                    refs[p][h] = 1;
                    a.ct = 16'd1;
                    return 1'b1;
                end
            end
            a.st = ST_ALREADY_LIVE;
            a.ct = 16'(refs[p][h]);
            return 1'b1;
        end
        c = refs[p][h];
        if (c == 0) begin
            a.st = ST_NOT_LIVE;
            return 1'b1;
        end
        if (k == KIND_REF) begin
            if (c >= CMAX) begin
                a.st = ST_COUNT_FULL;
                a.ct = 16'(c);
                return 1'b1;
            end
            refs[p][h] = c + 1;
            a.ct = 16'(c + 1);
            return 1'b1;
        end
        c = c - 1;
        refs[p][h] = c;
        if (c == 0 && free_n[p] < NHANDLE) begin
            free_ids[p][free_n[p]] = h;
            free_n[p] = free_n[p] + 1;
        end
        a.ct = 16'(c);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        answer_t a;
        answer_t want;
        if (!rst_n) begin
            clear_pools();
            answers_due.delete();
            errors = 0;
        end else begin
            if (in_valid && !in_stall) begin
                if (pool_answer(kind, pool_index, handle_in, a)) answers_due.push_back(a);
            end
            if (out_valid && !out_stall) begin
                a = '{st: status, pl: pool_out, hd: handle_out, ct: count_out};
                if (answers_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result st=%0d pool=%0d h=%0d cnt=%0d",
                                 a.st, a.pl, a.hd, a.ct);
                end else begin
                    want = answers_due.pop_front();
                    if (a !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp st=%0d pool=%0d h=%0d cnt=%0d, got st=%0d pool=%0d h=%0d cnt=%0d",
                                     want.st, want.pl, want.hd, want.ct,
                                     a.st, a.pl, a.hd, a.ct);
                    end
                end
            end
        end
    end

endmodule

[tb/refcounted_handle_pool_manager_core_tb.sv]
`timescale 1ns / 100ps
// testbench top for the handle pool manager: directed and random requests with
// random gaps and stalls; depends on rhp_pkg, the block and its checker
module refcounted_handle_pool_manager_core_tb;
    import rhp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [3:0]  pool_index;
    logic [9:0]  handle_in;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [3:0]  pool_out;
    logic [9:0]  handle_out;
    logic [15:0] count_out;
    int          errors;
    int          pending;

    // long receiver hold-off: requested by the stimulus, served by the receiver
    bit          squeeze_req;
    bit          squeeze_done;
    // no sender gaps while set
    bit          no_gaps;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_NEW;
        pool_index = '0;
        handle_in = '0;
        out_stall = 1'b0;
        squeeze_req = 1'b0;
        squeeze_done = 1'b0;
        no_gaps = 1'b0;
    end

    always #6 clk = ~clk;

    refcounted_handle_pool_manager_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .pool_index (pool_index),
        .handle_in  (handle_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .pool_out   (pool_out),
        .handle_out (handle_out),
        .count_out  (count_out)
    );

    refcounted_handle_pool_manager_core_chk chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .pool_index (pool_index),
        .handle_in  (handle_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .pool_out   (pool_out),
        .handle_out (handle_out),
        .count_out  (count_out),
        .errors     (errors),
        .pending    (pending)
    );

    // hard limit, well above the slowest legal run
    initial begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

    // one request: drive at the edge, wait for acceptance, then maybe idle
    task automatic issue(input logic [2:0] k, input logic [3:0] p, input logic [9:0] h);
        bit stalled;
        int r;
        int gap;
        kind <= k;
        pool_index <= p;
        handle_in <= h;
        in_valid <= 1'b1;
        // stall only moves at rising edges, so the falling-edge value holds for the next one
        forever begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
            if (!stalled) break;
        end
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver: short random stalls, some long ones, free-running stretches,
    // and once a long hold-off so the block backs up into its input
    initial begin
        int r;
        @(posedge rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (squeeze_req && !squeeze_done) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                squeeze_done = 1'b1;
            end else if (r < 50) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else if (r < 58) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(50, 300)) @(posedge clk);
            end else if (r < 92) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    initial begin
        int r;
        logic [2:0] k;
        logic [3:0] p;
        logic [9:0] h;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // basic life cycle on pool 0: allocate, ref, drop to zero, drop again
        issue(KIND_ALLOC, 4'd0, 10'd0);
        issue(KIND_REF, 4'd0, 10'd0);
        issue(KIND_UNREF, 4'd0, 10'd0);
        issue(KIND_UNREF, 4'd0, 10'd0);
        issue(KIND_UNREF, 4'd0, 10'd0);
        issue(KIND_REF, 4'd0, 10'd5);
        // import at the bottom of the stack, then import of a live id
        issue(KIND_IMPORT, 4'd0, 10'd1023);
        issue(KIND_IMPORT, 4'd0, 10'd1023);
        issue(KIND_REF, 4'd0, 10'd1023);
        issue(KIND_UNREF, 4'd0, 10'd1023);
        issue(KIND_UNREF, 4'd0, 10'd1023);
        issue(KIND_IMPORT, 4'd0, 10'd0);
        // retire, then every request on a dead pool
        issue(KIND_RETIRE, 4'd1, 10'd0);
        issue(KIND_RETIRE, 4'd1, 10'd0);
        issue(KIND_ALLOC, 4'd1, 10'd0);
        issue(KIND_IMPORT, 4'd15, 10'd1023);
        issue(KIND_REF, 4'd1, 10'd3);
        issue(KIND_UNREF, 4'd9, 10'd3);
        // unknown kinds give nothing back
        issue(3'd6, 4'd15, 10'd1023);
        issue(3'd7, 4'd0, 10'd0);
        // new pools until none is free
        for (int i = 0; i < 16; i++) issue(KIND_NEW, 4'd0, 10'd0);
        // drain pool 1 past empty
        no_gaps = 1'b1;
        for (int i = 0; i < 1025; i++) issue(KIND_ALLOC, 4'd1, 10'd0);
        // a few refs on one handle
        issue(KIND_ALLOC, 4'd2, 10'd0);
        for (int i = 0; i < 3; i++) issue(KIND_REF, 4'd2, 10'd0);
        no_gaps = 1'b0;
        issue(KIND_UNREF, 4'd2, 10'd0);
        // free some pools for the random part
        for (int i = 8; i < 16; i++) issue(KIND_RETIRE, 4'(i), 10'd0);

        // random part: mostly allocate, ref and unref on a few pools and low ids
        for (int n = 0; n < 250; n++) begin
            if (n == 100) squeeze_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3) k = KIND_NEW;
            else if (r < 7) k = KIND_RETIRE;
            else if (r < 32) k = KIND_ALLOC;
            else if (r < 40) k = KIND_IMPORT;
            else if (r < 68) k = KIND_REF;
            else if (r < 97) k = KIND_UNREF;
            else k = 3'($urandom_range(6, 7));
            p = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 3))
                                             : 4'($urandom_range(0, 15));
            h = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(0, 31))
                                             : 10'($urandom_range(0, 1023));
            issue(k, p, h);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (2100) @(posedge clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
